// File: rtl/mpte_pkg.sv
// Shared types and constants for the MessagePack token encoder.
`default_nettype none

package mpte_pkg;

  // Token kinds on the input channel; the remaining codes are ignored.
  typedef enum logic [3:0] {
    KIND_NIL     = 4'd0,
    KIND_BOOL    = 4'd1,
    KIND_INT     = 4'd2,
    KIND_FLOAT   = 4'd3,
    KIND_STR     = 4'd4,
    KIND_BIN     = 4'd5,
    KIND_ARRAY   = 4'd6,
    KIND_MAP     = 4'd7,
    KIND_PAYLOAD = 4'd8
  } mpte_kind_t;

  // Longest encoding: one code byte plus eight data bytes.
  localparam int FRAME_BYTES = 9;
  localparam int FRAME_W     = 8 * FRAME_BYTES;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
  } mpte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       range_error;
  } mpte_out_t;

  // Encoded token, left aligned; count of zero means nothing to send.
  typedef struct packed {
    logic [FRAME_W-1:0] data;
    logic [3:0]         count;
    logic               err;
  } mpte_frame_t;

endpackage

`default_nettype wire

// File: rtl/mpte_encode.sv
// Builds the complete MessagePack byte frame for one token.
`default_nettype none

module mpte_encode (
  input  mpte_pkg::mpte_in_t    token,
  output mpte_pkg::mpte_frame_t frame
);
  import mpte_pkg::*;

  localparam logic [7:0] CODE_NIL      = 8'hC0;
  localparam logic [7:0] CODE_FALSE    = 8'hC2;
  localparam logic [7:0] CODE_TRUE     = 8'hC3;
  localparam logic [7:0] CODE_UINT8    = 8'hCC;
  localparam logic [7:0] CODE_UINT16   = 8'hCD;
  localparam logic [7:0] CODE_UINT32   = 8'hCE;
  localparam logic [7:0] CODE_UINT64   = 8'hCF;
  localparam logic [7:0] CODE_INT8     = 8'hD0;
  localparam logic [7:0] CODE_INT16    = 8'hD1;
  localparam logic [7:0] CODE_INT32    = 8'hD2;
  localparam logic [7:0] CODE_INT64    = 8'hD3;
  localparam logic [7:0] CODE_FLOAT32  = 8'hCA;
  localparam logic [7:0] CODE_FLOAT64  = 8'hCB;
  localparam logic [7:0] CODE_FIXSTR   = 8'hA0;
  localparam logic [7:0] CODE_STR8     = 8'hD9;
  localparam logic [7:0] CODE_STR16    = 8'hDA;
  localparam logic [7:0] CODE_STR32    = 8'hDB;
  localparam logic [7:0] CODE_BIN8     = 8'hC4;
  localparam logic [7:0] CODE_BIN16    = 8'hC5;
  localparam logic [7:0] CODE_BIN32    = 8'hC6;
  localparam logic [7:0] CODE_FIXARRAY = 8'h90;
  localparam logic [7:0] CODE_ARRAY16  = 8'hDC;
  localparam logic [7:0] CODE_ARRAY32  = 8'hDD;
  localparam logic [7:0] CODE_FIXMAP   = 8'h80;
  localparam logic [7:0] CODE_MAP16    = 8'hDE;
  localparam logic [7:0] CODE_MAP32    = 8'hDF;

  // Code byte followed by the low nb bytes of v, most significant first.
  function automatic mpte_frame_t put_code(input logic [7:0] code, input logic [63:0] v,
                                           input logic [3:0] nb);
    mpte_frame_t f;
    f.err   = 1'b0;
    f.count = nb + 4'd1;
    case (nb)
      4'd1:    f.data = {code, v[7:0], 56'b0};
      4'd2:    f.data = {code, v[15:0], 48'b0};
      4'd4:    f.data = {code, v[31:0], 32'b0};
      4'd8:    f.data = {code, v};
      default: f.data = {code, 64'b0};
    endcase
    return f;
  endfunction

  logic [63:0] v;
  logic        neg;
  logic        len_big, len_lt16, len_lt32, len_lt255, len_lt65535;

  // Double to single narrowing
  logic        s;
  logic [10:0] e;
  logic [51:0] m;
  logic [52:0] sig, sig_sh, lo_mask;
  logic [10:0] sh_full;
  logic [5:0]  sh;
  logic [10:0] e_adj;
  logic        f_ok;
  logic [31:0] f32;

  assign v   = token.value;
  assign neg = v[63];

  assign len_big     = (v[63:32] != 32'b0) || (v[31:0] == 32'hFFFF_FFFF);
  assign len_lt16    = (v[63:4] == 60'b0);
  assign len_lt32    = (v[63:5] == 59'b0);
  assign len_lt255   = (v[63:8] == 56'b0) && (v[7:0] != 8'hFF);
  assign len_lt65535 = (v[63:16] == 48'b0) && (v[15:0] != 16'hFFFF);

  assign s       = v[63];
  assign e       = v[62:52];
  assign m       = v[51:0];
  assign sig     = {1'b1, m};
  assign sh_full = 11'd926 - e;
  assign sh      = sh_full[5:0];
  assign sig_sh  = sig >> sh;
  assign lo_mask = ~({53{1'b1}} << sh);
  assign e_adj   = e - 11'd896;

  always_comb begin
    f_ok = 1'b0;
    f32  = 32'b0;
    if (e == 11'h7FF) begin
      f_ok = (m == 52'b0);
      f32  = {s, 8'hFF, 23'b0};
    end else if (e == 11'd0) begin
      f_ok = (m == 52'b0);
      f32  = {s, 31'b0};
    end else if (e >= 11'd897 && e <= 11'd1150) begin
      f_ok = (m[28:0] == 29'b0);
      f32  = {s, e_adj[7:0], m[51:29]};
    end else if (e >= 11'd874 && e <= 11'd896) begin
      // lands in the single-precision subnormal range
      f_ok = ((sig & lo_mask) == 53'b0);
      f32  = {s, 8'b0, sig_sh[22:0]};
    end
  end

  always_comb begin
    frame = '0;
    case (token.kind)
      KIND_NIL:  frame = put_code(CODE_NIL, 64'b0, 4'd0);
      KIND_BOOL: frame = put_code(v[0] ? CODE_TRUE : CODE_FALSE, 64'b0, 4'd0);
      KIND_INT: begin
        if (!neg) begin
          if (v[63:7] == 57'b0)       frame = put_code(v[7:0], 64'b0, 4'd0);
          else if (v[63:8] == 56'b0)  frame = put_code(CODE_UINT8, v, 4'd1);
          else if (v[63:16] == 48'b0) frame = put_code(CODE_UINT16, v, 4'd2);
          else if (v[63:32] == 32'b0) frame = put_code(CODE_UINT32, v, 4'd4);
          else                        frame = put_code(CODE_UINT64, v, 4'd8);
        end else begin
          // negative fixint covers -31..-1 only
          if (v[63:5] == {59{1'b1}} && v[4:0] != 5'b0)
            frame = put_code(v[7:0], 64'b0, 4'd0);
          else if (v[63:7] == {57{1'b1}})  frame = put_code(CODE_INT8, v, 4'd1);
          else if (v[63:15] == {49{1'b1}}) frame = put_code(CODE_INT16, v, 4'd2);
          else if (v[63:31] == {33{1'b1}}) frame = put_code(CODE_INT32, v, 4'd4);
          else                             frame = put_code(CODE_INT64, v, 4'd8);
        end
      end
      KIND_FLOAT: begin
        if (f_ok) frame = put_code(CODE_FLOAT32, {32'b0, f32}, 4'd4);
        else      frame = put_code(CODE_FLOAT64, v, 4'd8);
      end
      KIND_STR: begin
        if (len_lt32)         frame = put_code(CODE_FIXSTR | {3'b0, v[4:0]}, 64'b0, 4'd0);
        else if (len_lt255)   frame = put_code(CODE_STR8, v, 4'd1);
        else if (len_lt65535) frame = put_code(CODE_STR16, v, 4'd2);
        else                  frame = put_code(CODE_STR32, v, 4'd4);
      end
      KIND_BIN: begin
        if (len_lt255)        frame = put_code(CODE_BIN8, v, 4'd1);
        else if (len_lt65535) frame = put_code(CODE_BIN16, v, 4'd2);
        else                  frame = put_code(CODE_BIN32, v, 4'd4);
      end
      KIND_ARRAY: begin
        if (len_lt16)         frame = put_code(CODE_FIXARRAY | {4'b0, v[3:0]}, 64'b0, 4'd0);
        else if (len_lt65535) frame = put_code(CODE_ARRAY16, v, 4'd2);
        else                  frame = put_code(CODE_ARRAY32, v, 4'd4);
      end
      KIND_MAP: begin
        if (len_lt16)         frame = put_code(CODE_FIXMAP | {4'b0, v[3:0]}, 64'b0, 4'd0);
        else if (len_lt65535) frame = put_code(CODE_MAP16, v, 4'd2);
        else                  frame = put_code(CODE_MAP32, v, 4'd4);
      end
      KIND_PAYLOAD: frame = put_code(v[7:0], 64'b0, 4'd0);
      default: frame = '0;
    endcase
    // oversize header: a single error word with a zero byte
    if ((token.kind == KIND_STR || token.kind == KIND_BIN || token.kind == KIND_ARRAY ||
         token.kind == KIND_MAP) && len_big) begin
      frame.data  = '0;
      frame.count = 4'd1;
      frame.err   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/msgpack_token_encoder_unit.sv
// Top level of the MessagePack token encoder: token register, encoder, byte shifter.
// A token moves from the token register through the encoder into the byte shifter.
// Throughput: one word per cycle while result_stall is low; a token of n bytes gives
//   n words (one for nil, bool, small ints, fix headers and payload, up to nine).
// Tokens of an unused kind are dropped in the token register without waiting for stage B.
// Reset (rst, synchronous, active high) empties both stages; no other state is kept.
`default_nettype none

module msgpack_token_encoder_unit (
  input  wire                 clk,
  input  wire                 rst,
  // token channel
  input  wire                 token_valid,
  output logic                token_stall,
  input  mpte_pkg::mpte_in_t  token,
  // result channel
  output logic                result_valid,
  input  wire                 result_stall,
  output mpte_pkg::mpte_out_t result
);
  import mpte_pkg::*;

  // Stage A: accepted token waiting for the encoder to hand it over.
  logic        a_valid;
  mpte_in_t    a_token;

  // Stage B: encoded frame, shifted out one byte per word.
  logic               b_valid;
  logic [3:0]         b_rem;     // bytes left including the one on the port
  logic [FRAME_W-1:0] b_data;
  logic               b_err;

  mpte_frame_t frame;
  logic        a_none;     // token makes no bytes
  logic        b_done;     // stage B can take a new frame this cycle
  logic        a_adv;      // stage A empties this cycle
  logic        b_load;
  logic        token_take;
  logic        b_shift;

  mpte_encode u_encode (
    .token (a_token),
    .frame (frame)
  );

  assign a_none     = (frame.count == 4'd0);
  assign b_done     = !b_valid || (!result_stall && b_rem == 4'd1);
  assign a_adv      = a_valid && (a_none || b_done);
  assign b_load     = a_adv && !a_none;
  assign b_shift    = b_valid && !result_stall;

  // Stage A frees up in the same cycle it hands over, so single-byte
  // tokens stream at one per cycle while result_stall is low.
  assign token_stall = a_valid && !a_adv;
  assign token_take  = token_valid && !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      b_rem   <= 4'd0;
    end else begin
      if (token_take) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end

      if (b_load) begin
        b_valid <= 1'b1;
        b_rem   <= frame.count;
      end else if (b_shift) begin
        if (b_rem == 4'd1) begin
          b_valid <= 1'b0;
        end
        b_rem <= b_rem - 4'd1;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (token_take) begin
      a_token <= token;
    end
    if (b_load) begin
      b_data <= frame.data;
      b_err  <= frame.err;
    end else if (b_shift) begin
      b_data <= {b_data[FRAME_W-9:0], 8'b0};
    end
  end

  assign result_valid       = b_valid;
  assign result.out_byte    = b_data[FRAME_W-1 -: 8];
  assign result.last        = (b_rem == 4'd1);
  assign result.range_error = b_err;

`ifndef SYNTHESIS
  // A frame in flight always has between one and nine bytes left.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_rem != 4'd0 && b_rem <= 4'(FRAME_BYTES)))
    else $error("byte count out of range");

  // An error word stands alone.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_error |-> result.last)
    else $error("range error on a word that is not last");

  // Taking a word that is not last leaves more of the same token.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |=> result_valid && !result.range_error)
    else $error("token cut short");

  // The token register never drops a token that still owes bytes.
  a_hold_token: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_adv |=> a_valid && $stable(a_token))
    else $error("pending token lost");
`endif

endmodule

`default_nettype wire
